// ===== hdl/rpa_pkg.sv =====
// Shared types and constants of the reference-counted page allocator.
package rpa_pkg;

	localparam int ADDR_W     = 27;
	localparam int S_DATA_W   = 32;
	localparam int S_USER_W   = 3;
	localparam int M_DATA_W   = 40;
	localparam int M_USER_W   = 3;
	localparam int OUT_CNT_W  = 8;
	localparam int FIRST_W    = 15;
	localparam int LIMIT_W    = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_FIRST_FREE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_PAGE_LIMIT = 1'b1;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'h8000;

	typedef enum logic [2:0] {
		ACT_INIT  = 3'd0,
		ACT_ALLOC = 3'd1,
		ACT_FREE  = 3'd2,
		ACT_INCR  = 3'd3,
		ACT_QUERY = 3'd4
	} act_t;

	typedef enum logic [2:0] {
		STAT_OK         = 3'd0,
		STAT_EMPTY      = 3'd1,
		STAT_FREE_UNREF = 3'd2,
		STAT_BAD_ADDR   = 3'd3,
		STAT_ALLOC_REF  = 3'd4,
		STAT_INCR_UNREF = 3'd5,
		STAT_OVERFLOW   = 3'd6
	} stat_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ALOC,
		ST_EXEC,
		ST_INIT
	} state_t;

endpackage

// ===== hdl/refcounted_page_allocator_core.sv =====
// Top level of the reference-counted page allocator.
//
// Input items arrive on s_*: s_tuser carries the action, s_tdata the byte
// address. Each item yields exactly one result on m_*: m_tuser carries the
// status, m_tdata the page address, the reference count and the release flag.
// first_free_page and page_limit are written through cfg_we/cfg_index/cfg_data.
//
// Per-page counts live in one memory, free page numbers in a second one used
// as a stack. Free, incr, query and unknown actions read the count and then
// load their result in the execute state; alloc reads the stack first, then
// the count. Init walks the pages of its range one at a time, bounded by the
// single write port of the count memory. One item is in flight at a time;
// s_tready returns the cycle after the result is loaded into the output
// register, so the next item is accepted only once the previous one is done.
//
// After reset all NUM_PAGES entries of the count memory are swept to zero, one
// entry per cycle; s_tready stays low during the sweep while configuration
// writes are still taken. When the receiver stalls, the result waits in the
// output register; the next item may be accepted meanwhile and waits for the
// register to free up before it completes.
module refcounted_page_allocator_core
	import rpa_pkg::*;
#(
	parameter int NUM_PAGES  = 32768,
	parameter int PAGE_BYTES = 4096,
	parameter int COUNT_BITS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [S_DATA_W-1:0]   s_tdata,   // [26:0] address
	input  logic [S_USER_W-1:0]   s_tuser,   // [2:0] action
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [M_DATA_W-1:0]   m_tdata,   // [26:0] page_address, [34:27] ref_count,
	                                         // [35] page_released
	output logic [M_USER_W-1:0]   m_tuser,   // [2:0] status
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int PN_W  = (NUM_PAGES > 2) ? $clog2(NUM_PAGES) : 1;
	localparam int OFF_W = $clog2(PAGE_BYTES);
	localparam int DP_W  = PN_W + 1;
	localparam int P_W   = (PN_W > LIMIT_W) ? PN_W : LIMIT_W;
	localparam int CX_W  = (COUNT_BITS > OUT_CNT_W) ? COUNT_BITS : OUT_CNT_W;
	localparam int PA_W  = PN_W + OFF_W;

	localparam logic [COUNT_BITS-1:0] CNT_MAX    = '1;
	localparam logic [COUNT_BITS-1:0] CNT_ONE    = COUNT_BITS'(1);
	localparam logic [DP_W-1:0]       DEPTH_FULL = DP_W'(NUM_PAGES);
	localparam logic [PN_W-1:0]       LAST_PAGE  = PN_W'(NUM_PAGES - 1);

	state_t state_q, state_d;

	logic [FIRST_W-1:0]    first_q;
	logic [LIMIT_W-1:0]    limit_q;
	logic [DP_W-1:0]       depth_q;
	logic [PN_W-1:0]       clr_q;
	logic [P_W-1:0]        p_q;
	logic [P_W-1:0]        hi_q;
	logic                  drop_q;
	act_t                  act_q;
	logic [ADDR_W-1:0]     addr_q;

	logic                  m_tvalid_q;
	stat_t                 status_q;
	logic [ADDR_W-1:0]     pa_q;
	logic [OUT_CNT_W-1:0]  cnt_q;
	logic                  rel_q;

	// memory ports
	logic                  ref_we, ref_re;
	logic [PN_W-1:0]       ref_waddr, ref_raddr;
	logic [COUNT_BITS-1:0] ref_wdata, ref_rdata;
	logic                  stk_we, stk_re;
	logic [PN_W-1:0]       stk_wdata, stk_raddr, stk_rdata;

	logic                  accept, can_load, load;
	logic                  depth_inc, depth_dec;
	act_t                  in_act;
	logic [ADDR_W-1:0]     in_addr;
	logic [31:0]           in_pn;
	logic [P_W-1:0]        in_hi;

	stat_t                 res_status;
	logic [ADDR_W-1:0]     res_pa;
	logic [COUNT_BITS-1:0] res_cnt;
	logic [CX_W-1:0]       res_cnt_x;
	logic                  res_rel;

	// execute-stage results
	stat_t                 ex_status;
	logic [ADDR_W-1:0]     ex_pa;
	logic [COUNT_BITS-1:0] ex_cnt;
	logic                  ex_rel;
	logic                  ex_ref_we, ex_stk_we, ex_inc, ex_dec;
	logic [PN_W-1:0]       ex_ref_waddr;
	logic [COUNT_BITS-1:0] ex_ref_wdata;
	logic [31:0]           ex_pn;
	logic [PN_W-1:0]       ex_idx;
	logic                  ex_oob, ex_over, ex_below, ex_unal;
	logic [PA_W-1:0]       ex_pa_full;

	rpa_ram #(.DEPTH(NUM_PAGES), .WIDTH(COUNT_BITS)) u_ref_ram (
		.clk   (clk),
		.we    (ref_we),
		.waddr (ref_waddr),
		.wdata (ref_wdata),
		.re    (ref_re),
		.raddr (ref_raddr),
		.rdata (ref_rdata)
	);

	rpa_ram #(.DEPTH(NUM_PAGES), .WIDTH(PN_W)) u_stk_ram (
		.clk   (clk),
		.we    (stk_we),
		.waddr (depth_q[PN_W-1:0]),
		.wdata (stk_wdata),
		.re    (stk_re),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	assign in_act   = act_t'(s_tuser);
	assign in_addr  = s_tdata[ADDR_W-1:0];
	assign in_pn    = 32'(in_addr >> OFF_W);
	assign in_hi    = (32'(limit_q) < 32'(NUM_PAGES)) ? P_W'(limit_q) : P_W'(NUM_PAGES);
	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign can_load = !m_tvalid_q || m_tready;

	assign ref_re    = (accept && in_act != ACT_ALLOC) || (state_q == ST_ALOC);
	assign ref_raddr = (state_q == ST_ALOC) ? stk_rdata : in_pn[PN_W-1:0];
	assign stk_re    = accept && in_act == ACT_ALLOC;
	assign stk_raddr = PN_W'(depth_q - DP_W'(1));

	// execute stage: read-modify-write decision on the fetched count
	always_comb begin
		ex_pn        = 32'(addr_q >> OFF_W);
		ex_idx       = ex_pn[PN_W-1:0];
		ex_oob       = ex_pn >= 32'(NUM_PAGES);
		ex_over      = ex_pn >= 32'(limit_q);
		ex_below     = ex_pn < 32'(first_q);
		ex_unal      = addr_q[OFF_W-1:0] != '0;
		ex_pa_full   = {stk_rdata, {OFF_W{1'b0}}};
		ex_status    = STAT_OK;
		ex_pa        = '0;
		ex_cnt       = '0;
		ex_rel       = 1'b0;
		ex_ref_we    = 1'b0;
		ex_ref_waddr = ex_idx;
		ex_ref_wdata = '0;
		ex_stk_we    = 1'b0;
		ex_inc       = 1'b0;
		ex_dec       = 1'b0;
		case (act_q)
			ACT_ALLOC: begin
				ex_ref_waddr = stk_rdata;
				if (depth_q == '0) begin
					ex_status = STAT_EMPTY;
				end else if (ref_rdata != '0) begin
					ex_status = STAT_ALLOC_REF;
				end else begin
					ex_dec       = 1'b1;
					ex_ref_we    = 1'b1;
					ex_ref_wdata = CNT_ONE;
					ex_pa        = ADDR_W'(ex_pa_full);
					ex_cnt       = CNT_ONE;
				end
			end
			ACT_QUERY: begin
				if (ex_oob) begin
					ex_status = STAT_BAD_ADDR;
				end else begin
					ex_cnt = ref_rdata;
				end
			end
			ACT_INCR: begin
				if (ex_oob || ex_over) begin
					ex_status = STAT_BAD_ADDR;
				end else if (ref_rdata == '0) begin
					ex_status = STAT_INCR_UNREF;
				end else if (ref_rdata == CNT_MAX) begin
					ex_status = STAT_OVERFLOW;
				end else begin
					ex_ref_we    = 1'b1;
					ex_ref_wdata = ref_rdata + CNT_ONE;
					ex_cnt       = ref_rdata + CNT_ONE;
				end
			end
			ACT_FREE: begin
				if (ex_oob) begin
					ex_status = STAT_BAD_ADDR;
				end else if (ref_rdata == '0) begin
					ex_status = STAT_FREE_UNREF;
				end else if (ref_rdata != CNT_ONE) begin
					ex_ref_we    = 1'b1;
					ex_ref_wdata = ref_rdata - CNT_ONE;
					ex_cnt       = ref_rdata - CNT_ONE;
				end else if (ex_unal || ex_below || ex_over) begin
					ex_status = STAT_BAD_ADDR;
				end else if (depth_q >= DEPTH_FULL) begin
					ex_status = STAT_OVERFLOW;
				end else begin
					ex_ref_we = 1'b1;
					ex_stk_we = 1'b1;
					ex_inc    = 1'b1;
					ex_rel    = 1'b1;
				end
			end
			default: begin
				ex_status = STAT_BAD_ADDR;
			end
		endcase
	end

	// next state, memory writes and result select
	always_comb begin
		state_d    = state_q;
		ref_we     = 1'b0;
		ref_waddr  = clr_q;
		ref_wdata  = '0;
		stk_we     = 1'b0;
		stk_wdata  = ex_idx;
		depth_inc  = 1'b0;
		depth_dec  = 1'b0;
		load       = 1'b0;
		res_status = drop_q ? STAT_OVERFLOW : STAT_OK;
		res_pa     = '0;
		res_cnt    = '0;
		res_rel    = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				ref_we = 1'b1;
				if (clr_q == LAST_PAGE) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (s_tvalid) begin
					case (in_act)
						ACT_INIT:  state_d = ST_INIT;
						ACT_ALLOC: state_d = ST_ALOC;
						default:   state_d = ST_EXEC;
					endcase
				end
			end
			ST_ALOC: begin
				state_d = ST_EXEC;
			end
			ST_EXEC: begin
				res_status = ex_status;
				res_pa     = ex_pa;
				res_cnt    = ex_cnt;
				res_rel    = ex_rel;
				ref_waddr  = ex_ref_waddr;
				ref_wdata  = ex_ref_wdata;
				if (can_load) begin
					load      = 1'b1;
					ref_we    = ex_ref_we;
					stk_we    = ex_stk_we;
					depth_inc = ex_inc;
					depth_dec = ex_dec;
					state_d   = ST_IDLE;
				end
			end
			ST_INIT: begin
				ref_waddr = p_q[PN_W-1:0];
				stk_wdata = p_q[PN_W-1:0];
				if (p_q < hi_q) begin
					ref_we = 1'b1;
					if (depth_q < DEPTH_FULL) begin
						stk_we    = 1'b1;
						depth_inc = 1'b1;
					end
				end else if (can_load) begin
					load    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q    <= '0;
			limit_q    <= LIMIT_RESET;
			depth_q    <= '0;
			clr_q      <= '0;
			drop_q     <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_FIRST_FREE: first_q <= cfg_data[FIRST_W-1:0];
					REG_PAGE_LIMIT: limit_q <= cfg_data[LIMIT_W-1:0];
					default:        ;
				endcase
			end
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + PN_W'(1);
			end
			if (depth_inc) begin
				depth_q <= depth_q + DP_W'(1);
			end else if (depth_dec) begin
				depth_q <= depth_q - DP_W'(1);
			end
			if (accept) begin
				drop_q <= 1'b0;
			end else if (state_q == ST_INIT && p_q < hi_q && depth_q >= DEPTH_FULL) begin
				drop_q <= 1'b1;
			end
			if (load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign res_cnt_x = CX_W'(res_cnt);

	always_ff @(posedge clk) begin
		if (accept) begin
			act_q  <= in_act;
			addr_q <= in_addr;
			p_q    <= P_W'(first_q);
			hi_q   <= in_hi;
		end else if (state_q == ST_INIT && p_q < hi_q) begin
			p_q <= p_q + P_W'(1);
		end
		if (load) begin
			status_q <= res_status;
			pa_q     <= res_pa;
			cnt_q    <= res_cnt_x[OUT_CNT_W-1:0];
			rel_q    <= res_rel;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = status_q;
	assign m_tdata  = {{(M_DATA_W - ADDR_W - OUT_CNT_W - 1){1'b0}}, rel_q, cnt_q, pa_q};

endmodule

// ===== hdl/rpa_ram.sv =====
// Single-port-write, single-port-read synchronous memory with registered read data.
module rpa_ram #(
	parameter int DEPTH = 32768,
	parameter int WIDTH = 8
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [$clog2(DEPTH)-1:0]         waddr,
	input  logic [WIDTH-1:0]                 wdata,
	input  logic                             re,
	input  logic [$clog2(DEPTH)-1:0]         raddr,
	output logic [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hdl/rpa_checker.sv =====
// Port-level checks of the page allocator core and their binding.
module rpa_checker
	import rpa_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                s_tvalid,
	input logic                s_tready,
	input logic                m_tvalid,
	input logic                m_tready,
	input logic [M_DATA_W-1:0] m_tdata,
	input logic [M_USER_W-1:0] m_tuser
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != STAT_OK |-> m_tdata == '0)
		else $error("error result carries nonzero payload");

	a_release: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[35] |-> m_tuser == STAT_OK && m_tdata[34:0] == '0)
		else $error("released page with inconsistent result");

	a_alloc_one: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[26:0] != '0 |-> m_tdata[34:27] == 8'd1)
		else $error("allocated page without count of one");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second item taken while one is in flight");

endmodule

bind refcounted_page_allocator_core rpa_checker u_rpa_checker (.*);

// ===== dv/refcounted_page_allocator_core_tb.sv =====
// Testbench for the reference-counted page allocator core: predicted versus observed replies.
`timescale 1ns / 100ps

module refcounted_page_allocator_core_tb;
	import rpa_pkg::*;

	localparam int PAGE_COUNT = 32768;
	localparam int PAGE_SIZE  = 4096;
	localparam int COUNT_MAX  = 255;

	localparam logic [2:0] ACT_BAD_LO = 3'd5;
	localparam logic [2:0] ACT_BAD_HI = 3'd7;
	localparam logic [ADDR_W-1:0] ADDR_TOP = '1;

	typedef struct packed {
		stat_t                status;
		logic [ADDR_W-1:0]    page_address;
		logic [OUT_CNT_W-1:0] ref_count;
		logic                 page_released;
	} page_reply_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [S_DATA_W-1:0]   s_tdata   = '0;   // [26:0] address
	logic [S_USER_W-1:0]   s_tuser   = '0;   // [2:0] action
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [M_DATA_W-1:0]   m_tdata;          // [26:0] page_address, [34:27] ref_count, [35] page_released
	logic [M_USER_W-1:0]   m_tuser;          // [2:0] status
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	// predicted allocator state
	logic [OUT_CNT_W-1:0] page_refs [PAGE_COUNT];
	logic [FIRST_W-1:0]   free_pages [PAGE_COUNT];
	int unsigned          free_depth = 0;
	logic [FIRST_W-1:0]   cfg_first  = '0;
	logic [LIMIT_W-1:0]   cfg_limit  = LIMIT_RESET;

	page_reply_t expected_replies [$];
	int unsigned live_pages [$];
	int unsigned mismatches = 0;
	int unsigned hold_left  = 0;
	bit          steady     = 1'b0;

	refcounted_page_allocator_core #(
		.NUM_PAGES (PAGE_COUNT),
		.PAGE_BYTES(PAGE_SIZE),
		.COUNT_BITS(8)
	) i_dut (.*);

	always #5 clk = ~clk;

	initial begin
		foreach (page_refs[i]) page_refs[i] = '0;
	end

	function automatic page_reply_t predict_page_op(input logic [2:0] act,
			input logic [ADDR_W-1:0] addr);
		page_reply_t r;
		int unsigned pn, hi, p, top, limit_bytes;
		logic [OUT_CNT_W-1:0] c;
		logic dropped;
		r = '0;
		r.status = STAT_OK;
		pn = addr / PAGE_SIZE;
		limit_bytes = cfg_limit * PAGE_SIZE;
		if (act == ACT_INIT) begin
			hi = (cfg_limit < PAGE_COUNT) ? cfg_limit : PAGE_COUNT;
			dropped = 1'b0;
			for (p = cfg_first; p < hi; p++) begin
				page_refs[p] = '0;
				if (free_depth < PAGE_COUNT) begin
					free_pages[free_depth] = FIRST_W'(p);
					free_depth++;
				end else
					dropped = 1'b1;
			end
			if (dropped)
				r.status = STAT_OVERFLOW;
			return r;
		end
		if (act == ACT_ALLOC) begin
			if (free_depth == 0) begin
				r.status = STAT_EMPTY;
				return r;
			end
			top = free_pages[free_depth-1];
			if (page_refs[top] != 0) begin
				r.status = STAT_ALLOC_REF;
				return r;
			end
			free_depth--;
			page_refs[top] = OUT_CNT_W'(1);
			r.page_address = ADDR_W'(top * PAGE_SIZE);
			r.ref_count = OUT_CNT_W'(1);
			return r;
		end
		if (act > ACT_QUERY || pn >= PAGE_COUNT) begin
			r.status = STAT_BAD_ADDR;
			return r;
		end
		c = page_refs[pn];
		case (act)
			ACT_QUERY: r.ref_count = c;
			ACT_INCR: begin
				if (addr >= limit_bytes)
					r.status = STAT_BAD_ADDR;
				else if (c == 0)
					r.status = STAT_INCR_UNREF;
				else if (c == COUNT_MAX)
					r.status = STAT_OVERFLOW;
				else begin
					page_refs[pn] = OUT_CNT_W'(c + 1);
					r.ref_count = OUT_CNT_W'(c + 1);
				end
			end
			default: begin
				if (c == 0)
					r.status = STAT_FREE_UNREF;
				else if (c > 1) begin
					page_refs[pn] = OUT_CNT_W'(c - 1);
					r.ref_count = OUT_CNT_W'(c - 1);
				end else if (addr % PAGE_SIZE != 0 || addr < cfg_first * PAGE_SIZE ||
						addr >= limit_bytes)
					r.status = STAT_BAD_ADDR;
				else if (free_depth >= PAGE_COUNT)
					r.status = STAT_OVERFLOW;
				else begin
					page_refs[pn] = '0;
					free_pages[free_depth] = FIRST_W'(pn);
					free_depth++;
					r.page_released = 1'b1;
				end
			end
		endcase
		return r;
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(99);
		if (steady || r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// mostly recently allocated pages, some with an offset, rest anywhere
	function automatic logic [ADDR_W-1:0] pick_address();
		int unsigned sel, pg;
		sel = $urandom_range(99);
		if (live_pages.size() != 0 && sel < 80) begin
			pg = live_pages[$urandom_range(live_pages.size() - 1)];
			if (sel < 70)
				return ADDR_W'(pg * PAGE_SIZE);
			return ADDR_W'(pg * PAGE_SIZE + $urandom_range(PAGE_SIZE - 1));
		end
		return ADDR_W'($urandom_range(ADDR_TOP));
	endfunction

	task automatic send_item(input logic [2:0] act, input logic [ADDR_W-1:0] addr,
			output page_reply_t want);
		int unsigned gap;
		gap = pick_gap();
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= {{(S_DATA_W - ADDR_W){1'b0}}, addr};
		do @(posedge clk); while (!s_tready);
		want = predict_page_op(act, addr);
		expected_replies.push_back(want);
		if (act == ACT_ALLOC && want.status == STAT_OK) begin
			live_pages.push_back(want.page_address / PAGE_SIZE);
			if (live_pages.size() > 48)
				void'(live_pages.pop_front());
		end
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (expected_replies.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic set_config(input logic [FIRST_W-1:0] first, input logic [LIMIT_W-1:0] limit);
		drain_results();
		cfg_we    <= 1'b1;
		cfg_index <= REG_FIRST_FREE;
		cfg_data  <= {1'b0, first};
		@(posedge clk);
		cfg_index <= REG_PAGE_LIMIT;
		cfg_data  <= limit;
		@(posedge clk);
		cfg_we    <= 1'b0;
		cfg_first = first;
		cfg_limit = limit;
	endtask

	task automatic test_directed();
		page_reply_t want;
		set_config(2, 6);
		send_item(ACT_ALLOC, '0, want);
		send_item(ACT_FREE, 3 * PAGE_SIZE, want);
		send_item(ACT_INCR, 3 * PAGE_SIZE, want);
		send_item(ACT_QUERY, 3 * PAGE_SIZE, want);
		send_item(ACT_BAD_HI, ADDR_TOP, want);
		send_item(ACT_BAD_LO, '0, want);
		send_item(ACT_INIT, '0, want);
		send_item(ACT_INIT, '0, want);
		repeat (5) send_item(ACT_ALLOC, '0, want);
		send_item(ACT_INCR, 5 * PAGE_SIZE, want);
		send_item(ACT_FREE, 5 * PAGE_SIZE, want);
		send_item(ACT_FREE, 5 * PAGE_SIZE + 1, want);
		send_item(ACT_INCR, 6 * PAGE_SIZE, want);
		send_item(ACT_QUERY, ADDR_TOP, want);
		send_item(ACT_FREE, 5 * PAGE_SIZE, want);
		set_config(4, 5);
		send_item(ACT_FREE, 3 * PAGE_SIZE, want);
		send_item(ACT_ALLOC, '0, want);
		send_item(ACT_FREE, 5 * PAGE_SIZE, want);
		send_item(ACT_FREE, 4 * PAGE_SIZE, want);
		send_item(ACT_QUERY, '0, want);
	endtask

	// fill the stack to the top, then init and free against a full stack
	task automatic test_stack_overflow();
		page_reply_t want;
		logic [ADDR_W-1:0] taken;
		set_config(0, LIMIT_RESET);
		send_item(ACT_INIT, '0, want);
		send_item(ACT_ALLOC, '0, want);
		taken = want.page_address;
		set_config(9, 10);
		send_item(ACT_INIT, '0, want);
		set_config(0, LIMIT_RESET);
		send_item(ACT_FREE, taken, want);
		send_item(ACT_ALLOC, '0, want);
		send_item(ACT_FREE, taken, want);
		set_config(100, 103);
		send_item(ACT_INIT, '0, want);
	endtask

	// walk one page's count up past its maximum and back to release
	task automatic test_count_saturation();
		page_reply_t want;
		int unsigned pg, k;
		set_config(0, LIMIT_RESET);
		send_item(ACT_ALLOC, '0, want);
		pg = want.page_address / PAGE_SIZE;
		for (k = 0; k <= COUNT_MAX; k++) begin
			send_item(ACT_INCR, ADDR_W'(pg * PAGE_SIZE), want);
			if ($urandom_range(7) == 0)
				send_item(ACT_QUERY,
					ADDR_W'(pg * PAGE_SIZE + $urandom_range(PAGE_SIZE - 1)), want);
		end
		for (k = 0; k < COUNT_MAX; k++)
			send_item(ACT_FREE, ADDR_W'(pg * PAGE_SIZE), want);
	endtask

	task automatic test_random_traffic();
		page_reply_t want;
		int unsigned phase, i, n, pick, span, hi;
		logic [FIRST_W-1:0] f;
		logic [LIMIT_W-1:0] l;
		logic [2:0] act;
		for (phase = 0; phase < 12; phase++) begin
			case (phase)
				0: begin f = FIRST_W'(PAGE_COUNT - 1); l = LIMIT_RESET; end
				1: begin f = '0; l = LIMIT_W'(1); end
				2: begin f = FIRST_W'(PAGE_COUNT - 1); l = LIMIT_W'(1); end
				3: begin f = '0; l = LIMIT_RESET; end
				default: begin
					f = FIRST_W'($urandom_range(PAGE_COUNT - 1));
					hi = f + $urandom_range(1, 96);
					if ($urandom_range(3) == 0)
						l = LIMIT_W'($urandom_range(1, PAGE_COUNT));
					else
						l = LIMIT_W'((hi > PAGE_COUNT) ? PAGE_COUNT : hi);
				end
			endcase
			set_config(f, l);
			span = (l > f) ? l - f : 0;
			steady = (phase % 4 == 1);
			n = $urandom_range(70, 118);
			for (i = 0; i < n; i++) begin
				pick = $urandom_range(99);
				if (pick < 3)
					act = (span <= 256) ? ACT_INIT : ACT_ALLOC;
				else if (pick < 28)
					act = ACT_ALLOC;
				else if (pick < 55)
					act = ACT_FREE;
				else if (pick < 80)
					act = ACT_INCR;
				else if (pick < 92)
					act = ACT_QUERY;
				else
					act = 3'($urandom_range(ACT_BAD_LO, ACT_BAD_HI));
				send_item(act, pick_address(), want);
				if ($urandom_range(199) == 0)
					drain_results();
			end
		end
		steady = 1'b0;
	endtask

	always @(posedge clk) begin : check_replies
		page_reply_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_replies.size() == 0) begin
				$error("reply with none expected: status %0d", m_tuser);
				mismatches++;
			end else begin
				want = expected_replies.pop_front();
				if (m_tuser !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, m_tuser);
					mismatches++;
				end
				if (m_tdata[26:0] !== want.page_address) begin
					$error("page_address: expected %0h, got %0h", want.page_address,
						m_tdata[26:0]);
					mismatches++;
				end
				if (m_tdata[34:27] !== want.ref_count) begin
					$error("ref_count: expected %0d, got %0d", want.ref_count, m_tdata[34:27]);
					mismatches++;
				end
				if (m_tdata[35] !== want.page_released) begin
					$error("page_released: expected %0d, got %0d", want.page_released,
						m_tdata[35]);
					mismatches++;
				end
			end
		end
		if (steady)
			hold_left = 0;
		else if (hold_left != 0)
			hold_left--;
		else if ($urandom_range(99) < 30)
			hold_left = ($urandom_range(9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
		m_tready <= (hold_left == 0);
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_stack_overflow();
		test_count_saturation();
		test_random_traffic();
		drain_results();
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#12_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

// ===== files.f =====
hdl/rpa_pkg.sv
hdl/rpa_ram.sv
hdl/refcounted_page_allocator_core.sv
hdl/rpa_checker.sv
dv/refcounted_page_allocator_core_tb.sv
